// File: rtl/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg
// Shared widths, register codes and bundle types of the ray / quad
// intersection pipeline.
// ----------------------------------------------------------------------------
package rqi_pkg;

    // field formats
    localparam int COORD_W    = 21;   // coordinate width, Q(COORD_W-11).11
    localparam int NRM_W      = 21;   // normal component, Q2.19
    localparam int IN_W       = 21;   // coordinate port width
    localparam int T_W        = 32;   // t, offset, Q16.16
    localparam int THR_W      = 16;
    localparam int PACK_W     = 63;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_SHIFT = 14;   // Q16.16 to units of 2^-30
    localparam int T_FRAC     = 16;

    // plane and divider widths
    localparam int NO_W  = NRM_W + COORD_W;
    localparam int DEN_W = NO_W + 2;
    localparam int NUM_W = 48;
    localparam int DVS_W = NO_W;
    localparam int DVD_W = NUM_W - 1 + T_FRAC;
    localparam int QB    = 33;                 // quotient bits kept
    localparam int TR_W  = DVS_W + QB + 1;
    localparam int TQ_W  = QB + 1;

    // hit point and barycentric widths
    localparam int TD_W = T_W + COORD_W;
    localparam int PT_W = TD_W - T_FRAC + 1;
    localparam int P_W  = PT_W + 1;
    localparam int C_W  = 2 * COORD_W + 1;
    localparam int W_W  = COORD_W + C_W + 1;
    localparam int DD_W = 2 * C_W + 2;
    localparam int AN_W = P_W + W_W + 2;

    // wide multiplier, split into digits
    localparam int MUL_W   = 66;
    localparam int DIG_W   = 22;
    localparam int MUL_OUT = 2 * MUL_W;
    localparam int MUL_LAT = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER = 3'd0,
        REG_EDGE_U = 3'd1,
        REG_EDGE_V = 3'd2,
        REG_NORMAL = 3'd3,
        REG_OFFSET = 3'd4,
        REG_THRESH = 3'd5
    } reg_idx_t;

    // configuration and the values derived from it
    typedef struct packed {
        logic [2:0][COORD_W-1:0] q;
        logic [2:0][NRM_W-1:0]   n;
        logic [T_W-1:0]          off;
        logic [THR_W-1:0]        thr;
        logic [2:0][W_W-1:0]     wa;
        logic [2:0][W_W-1:0]     wb;
        logic [DD_W-1:0]         dd;
    } cfg_view_t;

    // ray data riding along the divider
    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0][COORD_W-1:0] d;
        logic [T_W-1:0]          tmin;
        logic [T_W-1:0]          tmax;
        logic                    qneg;
        logic                    inner;
        logic                    par;
    } div_side_t;

endpackage

// File: rtl/rqi_wide_mul.sv
// ----------------------------------------------------------------------------
// rqi_wide_mul
// Signed multiplier built from digit partial products over three stages.
// ----------------------------------------------------------------------------
module rqi_wide_mul
    import rqi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [MUL_OUT-1:0] p
);

    localparam int ND    = MUL_W / DIG_W;
    localparam int PP_W  = 2 * DIG_W + 2;
    localparam int ROW_W = PP_W + (ND - 1) * DIG_W + 2;

    logic signed [DIG_W:0]      ad [ND];
    logic signed [DIG_W:0]      bd [ND];
    logic signed [PP_W-1:0]     pp_reg [ND][ND];
    logic signed [ROW_W-1:0]    row_next [ND];
    logic signed [ROW_W-1:0]    row_reg [ND];
    logic signed [MUL_OUT-1:0]  p_next;
    logic signed [MUL_OUT-1:0]  p_reg;

    // top digit signed, lower digits unsigned
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            if (i == ND - 1) begin
                ad[i] = $signed({a[MUL_W-1], a[i*DIG_W +: DIG_W]});
                bd[i] = $signed({b[MUL_W-1], b[i*DIG_W +: DIG_W]});
            end else begin
                ad[i] = $signed({1'b0, a[i*DIG_W +: DIG_W]});
                bd[i] = $signed({1'b0, b[i*DIG_W +: DIG_W]});
            end
        end
    end

    // row and final sums
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < ND; j++) begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) <<< (j * DIG_W));
            end
        end
        p_next = '0;
        for (int i = 0; i < ND; i++) begin
            p_next = p_next + (MUL_OUT'(row_reg[i]) <<< (i * DIG_W));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ND; i++) begin
                for (int j = 0; j < ND; j++) begin
                    pp_reg[i][j] <= PP_W'(ad[i] * bd[j]);
                end
                row_reg[i] <= row_next[i];
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/rqi_divider.sv
// ----------------------------------------------------------------------------
// rqi_divider
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow check at entry and the ray data carried alongside.
// ----------------------------------------------------------------------------
module rqi_divider
    import rqi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  div_side_t        in_side,
    output logic             out_valid,
    output logic [QB-1:0]    quot,
    output logic             ovf,
    output div_side_t        out_side
);

    logic [QB:0]       vld_reg;
    logic [QB:0]       ovf_reg;
    logic [DVD_W-1:0]  rem_reg [QB+1];
    logic [DVS_W-1:0]  dvs_reg [QB+1];
    logic [QB-1:0]     q_reg [QB+1];
    div_side_t         side_reg [QB+1];
    logic [DVD_W-1:0]  rem_next [1:QB];
    logic [QB-1:0]     q_next [1:QB];
    logic [TR_W-1:0]   trial [1:QB];
    logic              ovf_next;

    // quotient would not fit in QB bits
    assign ovf_next = TR_W'(dividend) >= (TR_W'(divisor) << QB);

    // one restoring step per stage, msb first
    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            trial[k] = TR_W'(rem_reg[k-1]) - (TR_W'(dvs_reg[k-1]) << (QB - k));
            if (!trial[k][TR_W-1]) begin
                rem_next[k] = trial[k][DVD_W-1:0];
                q_next[k]   = q_reg[k-1] | (QB'(1) << (QB - k));
            end else begin
                rem_next[k] = rem_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= dividend;
            dvs_reg[0]  <= divisor;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= in_side;
            for (int k = 1; k <= QB; k++) begin
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_reg[k-1];
                q_reg[k]    <= q_next[k];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign quot      = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

// File: rtl/rqi_cfg.sv
// ----------------------------------------------------------------------------
// rqi_cfg
// Configuration registers and the quad constants derived from them:
// C = U x V, V x C, C x U and C.C.
// ----------------------------------------------------------------------------
module rqi_cfg
    import rqi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_view_t            view
);

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic [PACK_W-1:0] corner_reg;
    logic [PACK_W-1:0] edge_u_reg;
    logic [PACK_W-1:0] edge_v_reg;
    logic [PACK_W-1:0] normal_reg;
    logic [T_W-1:0]    offset_reg;
    logic [THR_W-1:0]  thresh_reg;

    logic signed [COORD_W-1:0]   u_s [3];
    logic signed [COORD_W-1:0]   v_s [3];
    logic signed [2*COORD_W-1:0] uv_a_reg [3];
    logic signed [2*COORD_W-1:0] uv_b_reg [3];
    logic signed [C_W-1:0]       c_reg [3];
    logic signed [MUL_OUT-1:0]   wa_p0 [3];
    logic signed [MUL_OUT-1:0]   wa_p1 [3];
    logic signed [MUL_OUT-1:0]   wb_p0 [3];
    logic signed [MUL_OUT-1:0]   wb_p1 [3];
    logic signed [MUL_OUT-1:0]   dd_p [3];
    logic signed [W_W-1:0]       wa_reg [3];
    logic signed [W_W-1:0]       wb_reg [3];
    logic [DD_W-1:0]             dd_reg;
    logic [DD_W-1:0]             dd_next;

    // register writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= '0;
            edge_u_reg <= '0;
            edge_v_reg <= '0;
            normal_reg <= '0;
            offset_reg <= '0;
            thresh_reg <= THR_W'(1);
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_CORNER: corner_reg <= cfg_data[PACK_W-1:0];
                REG_EDGE_U: edge_u_reg <= cfg_data[PACK_W-1:0];
                REG_EDGE_V: edge_v_reg <= cfg_data[PACK_W-1:0];
                REG_NORMAL: normal_reg <= cfg_data[PACK_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[T_W-1:0];
                REG_THRESH: thresh_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // edge components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_s[i] = $signed(edge_u_reg[i*COORD_W +: COORD_W]);
            v_s[i] = $signed(edge_v_reg[i*COORD_W +: COORD_W]);
        end
    end

    // cross product U x V
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            uv_a_reg[i] <= u_s[NXT[i]] * v_s[PRV[i]];
            uv_b_reg[i] <= u_s[PRV[i]] * v_s[NXT[i]];
            c_reg[i]    <= C_W'(uv_a_reg[i]) - C_W'(uv_b_reg[i]);
        end
    end

    // V x C, C x U and C.C products
    for (genvar i = 0; i < 3; i++) begin : g_derive
        rqi_wide_mul u_wa0 (
            .aclk (aclk), .en (1'b1),
            .a (MUL_W'(v_s[NXT[i]])), .b (MUL_W'(c_reg[PRV[i]])), .p (wa_p0[i])
        );
        rqi_wide_mul u_wa1 (
            .aclk (aclk), .en (1'b1),
            .a (MUL_W'(v_s[PRV[i]])), .b (MUL_W'(c_reg[NXT[i]])), .p (wa_p1[i])
        );
        rqi_wide_mul u_wb0 (
            .aclk (aclk), .en (1'b1),
            .a (MUL_W'(c_reg[NXT[i]])), .b (MUL_W'(u_s[PRV[i]])), .p (wb_p0[i])
        );
        rqi_wide_mul u_wb1 (
            .aclk (aclk), .en (1'b1),
            .a (MUL_W'(c_reg[PRV[i]])), .b (MUL_W'(u_s[NXT[i]])), .p (wb_p1[i])
        );
        rqi_wide_mul u_dd (
            .aclk (aclk), .en (1'b1),
            .a (MUL_W'(c_reg[i])), .b (MUL_W'(c_reg[i])), .p (dd_p[i])
        );
    end

    assign dd_next = DD_W'(dd_p[0] + dd_p[1] + dd_p[2]);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            wa_reg[i] <= W_W'(wa_p0[i] - wa_p1[i]);
            wb_reg[i] <= W_W'(wb_p0[i] - wb_p1[i]);
        end
        dd_reg <= dd_next;
    end

    // bundle for the ray pipeline
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            view.q[i]  = corner_reg[i*COORD_W +: COORD_W];
            view.n[i]  = normal_reg[i*NRM_W +: NRM_W];
            view.wa[i] = wa_reg[i];
            view.wb[i] = wb_reg[i];
        end
        view.off = offset_reg;
        view.thr = thresh_reg;
        view.dd  = dd_reg;
    end

endmodule

// File: rtl/ray_quad_intersect.sv
// ----------------------------------------------------------------------------
// ray_quad_intersect
// Tests each ray against a configured parallelogram and returns t, the hit
// point, the facing normal and the face that was hit.
//
//  channel   direction  handshake            beat
//  s_        in         s_valid / s_ready    one ray and its t range
//  m_        out        m_valid / m_ready    one hit record per ray
//  cfg_      in         cfg_valid / cfg_ready  one register write
//
//  One ray per cycle while the pipeline is not stalled; most of the pipeline
//  depth lies in the restoring divider for t.
//  Reset (aresetn low, synchronous) empties the pipeline, threshold goes to 1.
//  A held output beat stalls the pipeline only once its last stage is full.
//  Derived quad constants settle after a register write via U x V, C and the wide multipliers.
// ----------------------------------------------------------------------------
module ray_quad_intersect
    import rqi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [IN_W-1:0] s_origin_x,
    input  logic signed [IN_W-1:0] s_origin_y,
    input  logic signed [IN_W-1:0] s_origin_z,
    input  logic signed [IN_W-1:0] s_dir_x,
    input  logic signed [IN_W-1:0] s_dir_y,
    input  logic signed [IN_W-1:0] s_dir_z,
    input  logic signed [T_W-1:0]  s_t_min,
    input  logic signed [T_W-1:0]  s_t_max,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic signed [T_W-1:0]  m_t_hit,
    output logic signed [IN_W-1:0] m_point_x,
    output logic signed [IN_W-1:0] m_point_y,
    output logic signed [IN_W-1:0] m_point_z,
    output logic signed [NRM_W-1:0] m_face_normal_x,
    output logic signed [NRM_W-1:0] m_face_normal_y,
    output logic signed [NRM_W-1:0] m_face_normal_z,
    output logic                  m_inside_face,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    typedef struct packed {
        logic                  ok;
        logic                  inner;
        logic [T_W-1:0]        t;
        logic [2:0][PT_W-1:0]  pt;
    } tail_t;

    localparam logic signed [PT_W-1:0]  PT_MAX = PT_W'((1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [PT_W-1:0]  PT_MIN = -PT_MAX - PT_W'(1);
    localparam logic signed [NRM_W:0]   N_MAX  = (NRM_W+1)'((1 <<< (NRM_W - 1)) - 1);

    cfg_view_t view;
    logic pipe_en;
    logic in_fire;

    logic signed [COORD_W-1:0] q_s [3];
    logic signed [NRM_W-1:0]   n_s [3];
    logic signed [COORD_W-1:0] o_in [3];
    logic signed [COORD_W-1:0] d_in [3];

    // stage 1
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_o_reg [3];
    logic signed [COORD_W-1:0] s1_d_reg [3];
    logic signed [T_W-1:0]     s1_tmin_reg, s1_tmax_reg;
    logic signed [NO_W-1:0]    s1_nd_reg [3];
    logic signed [NO_W-1:0]    s1_no_reg [3];
    // stage 2
    logic                      s2_valid_reg;
    logic signed [COORD_W-1:0] s2_o_reg [3];
    logic signed [COORD_W-1:0] s2_d_reg [3];
    logic signed [T_W-1:0]     s2_tmin_reg, s2_tmax_reg;
    logic signed [DEN_W-1:0]   s2_den_reg, s2_den_next;
    logic signed [NUM_W-1:0]   s2_num_reg, s2_num_next;
    // stage 3
    logic                      s3_valid_reg;
    logic [DVD_W-1:0]          s3_dvd_reg, s3_dvd_next;
    logic [DVS_W-1:0]          s3_dvs_reg;
    div_side_t                 s3_side_reg, s3_side_next;
    logic signed [DEN_W-1:0]   den_abs;
    logic signed [NUM_W-1:0]   num_abs;
    // divider out
    logic                      dv_valid;
    logic [QB-1:0]             dv_quot;
    logic                      dv_ovf;
    div_side_t                 dv_side;
    // t stage
    logic                      st_valid_reg;
    logic                      st_ok_reg, st_ok_next;
    logic                      st_inside_reg;
    logic signed [T_W-1:0]     st_t_reg;
    logic signed [TQ_W-1:0]    t_full;
    logic signed [TQ_W-1:0]    q_ext;
    logic signed [COORD_W-1:0] st_o_reg [3];
    logic signed [COORD_W-1:0] st_d_reg [3];
    // t*d stage
    logic                      sm_valid_reg;
    logic                      sm_ok_reg, sm_inside_reg;
    logic signed [T_W-1:0]     sm_t_reg;
    logic signed [COORD_W-1:0] sm_o_reg [3];
    logic signed [TD_W-1:0]    sm_td_reg [3];
    // hit point stage
    logic                      sp_valid_reg;
    tail_t                     sp_tail_reg;
    logic signed [PT_W-1:0]    pt_next [3];
    logic signed [P_W-1:0]     sp_p_reg [3];
    logic signed [MUL_OUT-1:0] an_p [3];
    logic signed [MUL_OUT-1:0] bn_p [3];
    // multiplier delay line
    logic [MUL_LAT-1:0]        dl_valid_reg;
    tail_t                     dl_tail_reg [MUL_LAT];
    // barycentric sum stage
    logic                      sa_valid_reg;
    tail_t                     sa_tail_reg;
    logic signed [AN_W-1:0]    sa_an_reg, sa_bn_reg;
    // output
    logic                      m_valid_reg;
    logic                      hit_next;
    logic signed [AN_W-1:0]    dd_s;
    logic signed [PT_W-1:0]    pt_sat [3];
    logic signed [NRM_W:0]     nrm_neg [3];
    logic signed [NRM_W-1:0]   face_n [3];
    logic                      out_hit_reg;
    logic signed [T_W-1:0]     out_t_reg;
    logic signed [IN_W-1:0]    out_pt_reg [3];
    logic signed [NRM_W-1:0]   out_n_reg [3];
    logic                      out_inside_reg;

    rqi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    assign cfg_ready = 1'b1;

    // pipeline moves unless a full last stage faces a held output beat
    assign pipe_en = !m_valid_reg || m_ready || !sa_valid_reg;
    assign s_ready = pipe_en;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_s[i] = $signed(view.q[i]);
            n_s[i] = $signed(view.n[i]);
        end
        o_in[0] = $signed(s_origin_x[COORD_W-1:0]);
        o_in[1] = $signed(s_origin_y[COORD_W-1:0]);
        o_in[2] = $signed(s_origin_z[COORD_W-1:0]);
        d_in[0] = $signed(s_dir_x[COORD_W-1:0]);
        d_in[1] = $signed(s_dir_y[COORD_W-1:0]);
        d_in[2] = $signed(s_dir_z[COORD_W-1:0]);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
            sp_valid_reg <= 1'b0;
            dl_valid_reg <= '0;
            sa_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            st_valid_reg <= dv_valid;
            sm_valid_reg <= st_valid_reg;
            sp_valid_reg <= sm_valid_reg;
            dl_valid_reg <= {dl_valid_reg[MUL_LAT-2:0], sp_valid_reg};
            sa_valid_reg <= dl_valid_reg[MUL_LAT-1];
        end
    end

    // stage 1: normal products with direction and origin
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                s1_o_reg[i]  <= o_in[i];
                s1_d_reg[i]  <= d_in[i];
                s1_nd_reg[i] <= n_s[i] * d_in[i];
                s1_no_reg[i] <= n_s[i] * o_in[i];
            end
            s1_tmin_reg <= s_t_min;
            s1_tmax_reg <= s_t_max;
        end
    end

    // stage 2: den = N.R, num = D - N.O
    assign s2_den_next = DEN_W'(s1_nd_reg[0]) + DEN_W'(s1_nd_reg[1]) + DEN_W'(s1_nd_reg[2]);
    assign s2_num_next = (NUM_W'($signed(view.off)) <<< FRAC_SHIFT)
                       - NUM_W'(s1_no_reg[0]) - NUM_W'(s1_no_reg[1]) - NUM_W'(s1_no_reg[2]);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_o_reg    <= s1_o_reg;
            s2_d_reg    <= s1_d_reg;
            s2_tmin_reg <= s1_tmin_reg;
            s2_tmax_reg <= s1_tmax_reg;
            s2_den_reg  <= s2_den_next;
            s2_num_reg  <= s2_num_next;
        end
    end

    // stage 3: magnitudes, signs, parallel test
    always_comb begin
        den_abs     = s2_den_reg[DEN_W-1] ? -s2_den_reg : s2_den_reg;
        num_abs     = s2_num_reg[NUM_W-1] ? -s2_num_reg : s2_num_reg;
        s3_dvd_next = {num_abs[NUM_W-2:0], {T_FRAC{1'b0}}};
        for (int i = 0; i < 3; i++) begin
            s3_side_next.o[i] = s2_o_reg[i];
            s3_side_next.d[i] = s2_d_reg[i];
        end
        s3_side_next.tmin   = s2_tmin_reg;
        s3_side_next.tmax   = s2_tmax_reg;
        s3_side_next.qneg   = s2_num_reg[NUM_W-1] ^ s2_den_reg[DEN_W-1];
        s3_side_next.inner  = !s2_den_reg[DEN_W-1] && (s2_den_reg != '0);
        s3_side_next.par    = $unsigned(den_abs)
                            <= (DEN_W'(view.thr) << FRAC_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_dvd_reg  <= s3_dvd_next;
            s3_dvs_reg  <= den_abs[DVS_W-1:0];
            s3_side_reg <= s3_side_next;
        end
    end

    rqi_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_dvd_reg),
        .divisor   (s3_dvs_reg),
        .in_side   (s3_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .ovf       (dv_ovf),
        .out_side  (dv_side)
    );

    // signed t and range test, with the overflow and parallel checks
    assign q_ext  = $signed({1'b0, dv_quot});
    assign t_full = dv_side.qneg ? -q_ext : q_ext;
    assign st_ok_next = !dv_ovf && !dv_side.par
                     && (t_full >= TQ_W'($signed(dv_side.tmin)))
                     && (t_full <= TQ_W'($signed(dv_side.tmax)));

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st_ok_reg     <= st_ok_next;
            st_inside_reg <= dv_side.inner;
            st_t_reg      <= t_full[T_W-1:0];
            for (int i = 0; i < 3; i++) begin
                st_o_reg[i] <= $signed(dv_side.o[i]);
                st_d_reg[i] <= $signed(dv_side.d[i]);
            end
        end
    end

    // t * R
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sm_ok_reg     <= st_ok_reg;
            sm_inside_reg <= st_inside_reg;
            sm_t_reg      <= st_t_reg;
            for (int i = 0; i < 3; i++) begin
                sm_o_reg[i]  <= st_o_reg[i];
                sm_td_reg[i] <= st_t_reg * st_d_reg[i];
            end
        end
    end

    // hit point, floored, and P - Q
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt_next[i] = PT_W'(sm_o_reg[i]) + PT_W'(sm_td_reg[i] >>> T_FRAC);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sp_tail_reg.ok     <= sm_ok_reg;
            sp_tail_reg.inner  <= sm_inside_reg;
            sp_tail_reg.t      <= sm_t_reg;
            for (int i = 0; i < 3; i++) begin
                sp_tail_reg.pt[i] <= pt_next[i];
                sp_p_reg[i]       <= P_W'(pt_next[i]) - P_W'(q_s[i]);
            end
        end
    end

    // barycentric numerators: p.(V x C) and p.(C x U)
    for (genvar i = 0; i < 3; i++) begin : g_bary
        rqi_wide_mul u_an (
            .aclk (aclk), .en (pipe_en),
            .a (MUL_W'(sp_p_reg[i])), .b (MUL_W'($signed(view.wa[i]))), .p (an_p[i])
        );
        rqi_wide_mul u_bn (
            .aclk (aclk), .en (pipe_en),
            .a (MUL_W'(sp_p_reg[i])), .b (MUL_W'($signed(view.wb[i]))), .p (bn_p[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dl_tail_reg[0] <= sp_tail_reg;
            for (int k = 1; k < MUL_LAT; k++) begin
                dl_tail_reg[k] <= dl_tail_reg[k-1];
            end
            sa_tail_reg <= dl_tail_reg[MUL_LAT-1];
            sa_an_reg   <= AN_W'(an_p[0]) + AN_W'(an_p[1]) + AN_W'(an_p[2]);
            sa_bn_reg   <= AN_W'(bn_p[0]) + AN_W'(bn_p[1]) + AN_W'(bn_p[2]);
        end
    end

    // final hit decision, saturation and facing normal
    assign dd_s = AN_W'(view.dd);
    assign hit_next = sa_tail_reg.ok && (view.dd != '0)
                   && !sa_an_reg[AN_W-1] && (sa_an_reg <= dd_s)
                   && !sa_bn_reg[AN_W-1] && (sa_bn_reg <= dd_s);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if ($signed(sa_tail_reg.pt[i]) > PT_MAX) begin
                pt_sat[i] = PT_MAX;
            end else if ($signed(sa_tail_reg.pt[i]) < PT_MIN) begin
                pt_sat[i] = PT_MIN;
            end else begin
                pt_sat[i] = $signed(sa_tail_reg.pt[i]);
            end
            nrm_neg[i] = -((NRM_W+1)'(n_s[i]));
            if (!sa_tail_reg.inner) begin
                face_n[i] = n_s[i];
            end else if (nrm_neg[i] > N_MAX) begin
                face_n[i] = N_MAX[NRM_W-1:0];
            end else begin
                face_n[i] = nrm_neg[i][NRM_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_hit_reg    <= hit_next;
            out_t_reg      <= hit_next ? $signed(sa_tail_reg.t) : '0;
            out_inside_reg <= hit_next && sa_tail_reg.inner;
            for (int i = 0; i < 3; i++) begin
                out_pt_reg[i] <= hit_next ? IN_W'($signed(pt_sat[i][COORD_W-1:0])) : '0;
                out_n_reg[i]  <= hit_next ? face_n[i] : '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_t_hit         = out_t_reg;
    assign m_point_x       = out_pt_reg[0];
    assign m_point_y       = out_pt_reg[1];
    assign m_point_z       = out_pt_reg[2];
    assign m_face_normal_x = out_n_reg[0];
    assign m_face_normal_y = out_n_reg[1];
    assign m_face_normal_z = out_n_reg[2];
    assign m_inside_face   = out_inside_reg;

endmodule

// File: rtl/rqi_checker.sv
// ----------------------------------------------------------------------------
// rqi_checker
// Port-level checks on the hit records of the intersection pipeline.
// ----------------------------------------------------------------------------
module rqi_checker
    import rqi_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_hit,
    input logic signed [T_W-1:0]  m_t_hit,
    input logic signed [IN_W-1:0] m_point_x,
    input logic signed [IN_W-1:0] m_point_y,
    input logic signed [IN_W-1:0] m_point_z,
    input logic signed [NRM_W-1:0] m_face_normal_x,
    input logic signed [NRM_W-1:0] m_face_normal_y,
    input logic signed [NRM_W-1:0] m_face_normal_z,
    input logic                   m_inside_face
);

    // a miss carries an all-zero record
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_t_hit == '0) && (m_point_x == '0) && (m_point_y == '0)
            && (m_point_z == '0) && (m_face_normal_x == '0) && (m_face_normal_y == '0)
            && (m_face_normal_z == '0))
        else $error("miss beat with nonzero fields");

    // inside face only reported on a hit
    a_inside_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_face |-> m_hit)
        else $error("inside face without hit");

    // held beat keeps its hit flag and t
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_t_hit))
        else $error("output beat changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind ray_quad_intersect rqi_checker u_rqi_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ray_quad_intersect. Rays aimed at configured
// parallelograms, plus random noise, go in with random input gaps and
// random result backpressure; every hit record is compared against an
// in-bench fixed-point predictor that tracks the register file.
// ----------------------------------------------------------------------------
module tb_top
    import rqi_pkg::*;
;

    localparam int LIMIT = 5000;      // cycles without any beat
    localparam int DRAIN = 60;        // pipeline depth plus margin
    localparam int SETTLE = 12;       // derived constants after a write
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0][20:0] o;
        logic [2:0][20:0] d;
        logic [31:0]      tmin;
        logic [31:0]      tmax;
    } ray_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      t_hit;
        logic [2:0][20:0] pt;
        logic [2:0][20:0] fn;
        logic             inner;
    } hit_rec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic signed [IN_W-1:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic signed [T_W-1:0]  s_t_min = '0, s_t_max = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit, m_inside_face;
    logic signed [T_W-1:0]  m_t_hit;
    logic signed [IN_W-1:0] m_point_x, m_point_y, m_point_z;
    logic signed [NRM_W-1:0] m_face_normal_x, m_face_normal_y, m_face_normal_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // register file copy
    logic [62:0] quad_corner = '0, quad_edge_u = '0, quad_edge_v = '0, quad_normal = '0;
    logic [31:0] quad_offset = '0;
    logic [15:0] par_thresh = 16'd1;

    hit_rec_t hit_q[$];
    int  n_rays = 0, n_hits = 0, n_records = 0, n_writes = 0, n_bad = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    ray_quad_intersect dut (.*);

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint sx(logic [63:0] v, int w);
        longint tmp;
        tmp = longint'(v << (64 - w));
        return tmp >>> (64 - w);
    endfunction

    function automatic logic signed [127:0] dot3(longint a[3], longint b[3]);
        logic signed [127:0] s, x, y;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            x = a[i];
            y = b[i];
            s += x * y;
        end
        return s;
    endfunction

    function automatic void cross3(longint a[3], longint b[3], output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // expected hit record of one ray under the current registers
    function automatic hit_rec_t predict_hit(ray_t r);
        hit_rec_t e;
        longint q[3], u[3], v[3], n[3], o[3], d[3], pt[3], p[3], c[3], pv[3], up[3];
        longint den, num, t, x, lo, hi;
        logic signed [127:0] dd, an, bn;
        e = '0;
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++) begin
            q[i] = sx(quad_corner >> (21 * i), 21);
            u[i] = sx(quad_edge_u >> (21 * i), 21);
            v[i] = sx(quad_edge_v >> (21 * i), 21);
            n[i] = sx(quad_normal >> (21 * i), 21);
            o[i] = sx(r.o[i], 21);
            d[i] = sx(r.d[i], 21);
            den += n[i] * d[i];
            num -= n[i] * o[i];
        end
        // nearly parallel to the plane
        if ((den < 0 ? -den : den) <= longint'({48'd0, par_thresh}) * 16384) return e;
        num += sx(quad_offset, 32) * 16384;
        t = (num * 65536) / den;
        lo = sx(r.tmin, 32);
        hi = sx(r.tmax, 32);
        if (t < lo || t > hi) return e;
        for (int i = 0; i < 3; i++) begin
            x = (t * d[i]) >>> 16;
            pt[i] = o[i] + x;
            p[i] = pt[i] - q[i];
        end
        cross3(u, v, c);
        cross3(p, v, pv);
        cross3(u, p, up);
        dd = dot3(c, c);
        // degenerate quad
        if (dd == 0) return e;
        an = dot3(c, pv);
        bn = dot3(c, up);
        if (an < 0 || an > dd || bn < 0 || bn > dd) return e;
        e.hit = 1'b1;
        e.t_hit = t[31:0];
        for (int i = 0; i < 3; i++) begin
            x = pt[i] < -1048576 ? -1048576 : (pt[i] > 1048575 ? 1048575 : pt[i]);
            e.pt[i] = x[20:0];
            x = den > 0 ? -n[i] : n[i];
            if (x > 1048575) x = 1048575;
            e.fn[i] = x[20:0];
        end
        e.inner = den > 0;
        return e;
    endfunction

    function automatic logic [63:0] pack3(longint x, longint y, longint z);
        return {1'($urandom_range(0, 1)), z[20:0], y[20:0], x[20:0]};
    endfunction

    function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz, tmin, tmax);
        ray_t r;
        r.o = {oz[20:0], oy[20:0], ox[20:0]};
        r.d = {dz[20:0], dy[20:0], dx[20:0]};
        r.tmin = tmin[31:0];
        r.tmax = tmax[31:0];
        return r;
    endfunction

    // ray through quad point (ku, kv)/1024, starting at that point plus off
    function automatic ray_t aim(int ku, int kv, longint fx, fy, fz, tmin, tmax);
        longint tg[3], f[3];
        f = '{fx, fy, fz};
        for (int i = 0; i < 3; i++)
            tg[i] = sx(quad_corner >> (21 * i), 21)
                  + (sx(quad_edge_u >> (21 * i), 21) * ku) / 1024
                  + (sx(quad_edge_v >> (21 * i), 21) * kv) / 1024;
        return mk_ray(tg[0] + f[0], tg[1] + f[1], tg[2] + f[2], -f[0], -f[1], -f[2],
                      tmin, tmax);
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        r.o = 63'({$urandom, $urandom});
        r.d = 63'({$urandom, $urandom});
        r.tmin = $urandom;
        r.tmax = $urandom;
        return r;
    endfunction

    function automatic ray_t random_aimed();
        longint tmin, tmax;
        tmin = 0;
        tmax = 32'h7fff_ffff;
        if ($urandom_range(0, 3) == 0) begin
            tmin = $urandom_range(0, 32'h0002_0000);
            tmax = $urandom_range(32'h0000_8000, 32'h0003_0000);
        end
        return aim($urandom_range(0, 1152) - 64, $urandom_range(0, 1152) - 64,
                   longint'($urandom_range(0, 262144)) - 131072,
                   longint'($urandom_range(0, 262144)) - 131072,
                   longint'($urandom_range(0, 262144)) - 131072, tmin, tmax);
    endfunction

    // one ray beat; valid stays up into the next call unless a gap comes
    task automatic send_ray(ray_t r);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_origin_z, s_origin_y, s_origin_x} <= r.o;
        {s_dir_z, s_dir_y, s_dir_x} <= r.d;
        s_t_min <= r.tmin;
        s_t_max <= r.tmax;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit_q.push_back(predict_hit(r));
        n_rays++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        n_writes++;
        case (idx)
            REG_CORNER: quad_corner = val[62:0];
            REG_EDGE_U: quad_edge_u = val[62:0];
            REG_EDGE_V: quad_edge_v = val[62:0];
            REG_NORMAL: quad_normal = val[62:0];
            REG_OFFSET: quad_offset = val[31:0];
            REG_THRESH: par_thresh = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_quad(logic [63:0] q, u, v, n, logic [31:0] off, logic [15:0] thr);
        wait_drained();
        write_reg(REG_CORNER, q);
        write_reg(REG_EDGE_U, u);
        write_reg(REG_EDGE_V, v);
        write_reg(REG_NORMAL, n);
        write_reg(REG_OFFSET, {$urandom, off});
        write_reg(REG_THRESH, {$urandom, 16'($urandom_range(0, 65535)), thr});
        cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge aclk);
    endtask

    // axis-aligned quad with a skewed V edge
    task automatic random_quad();
        longint q[3], u[3], v[3], n[3], nm, thr;
        int a, b, c;
        a = $urandom_range(0, 2);
        b = (a + 1) % 3;
        c = (a + 2) % 3;
        for (int i = 0; i < 3; i++) begin
            q[i] = longint'($urandom_range(0, 524288)) - 262144;
            u[i] = 0;
            v[i] = 0;
            n[i] = 0;
        end
        u[b] = longint'($urandom_range(1024, 262144)) * ($urandom_range(0, 1) ? 1 : -1);
        v[c] = longint'($urandom_range(1024, 262144)) * ($urandom_range(0, 1) ? 1 : -1);
        v[b] = longint'($urandom_range(0, 8192)) - 4096;
        case ($urandom_range(0, 3))
            0: nm = 524288;
            1: nm = -524288;
            2: nm = -1048576;
            default: nm = longint'($urandom_range(1024, 1048575));
        endcase
        n[a] = nm;
        case ($urandom_range(0, 3))
            0: thr = 0;
            1: thr = 65535;
            2: thr = 1;
            default: thr = $urandom_range(0, 65535);
        endcase
        set_quad(pack3(q[0], q[1], q[2]), pack3(u[0], u[1], u[2]), pack3(v[0], v[1], v[2]),
                 pack3(n[0], n[1], n[2]), 32'((nm * q[a]) >>> 14), thr[15:0]);
    endtask

    // registers at reset: zero normal, every ray parallel
    task automatic test_reset_state();
        repeat (4) send_ray(noise_ray());
    endtask

    task automatic test_directed();
        // 16 x 16 quad at z = 2, normal +z
        set_quad(pack3(-16384, -16384, 4096), pack3(32768, 0, 0), pack3(0, 32768, 0),
                 pack3(0, 0, 524288), 32'(4096 * 32), 16'd1);
        send_ray(aim(512, 512, 1000, -2000, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(0, 0, 0, 0, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(1024, 1024, 0, 0, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(1024, 0, 300, 0, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(-4, 512, 0, 0, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(512, 1030, 0, 0, 8192, 0, 32'h7fff_ffff));
        // inside face, ray travels along the normal
        send_ray(aim(300, 700, 0, 0, -8192, 0, 32'h7fff_ffff));
        // parallel ray
        send_ray(mk_ray(0, 0, 8192, 1000, 500, 0, 0, 32'h7fff_ffff));
        // t out of range, reversed range, exact bounds
        send_ray(aim(512, 512, 0, 0, 8192, 0, 32'h8000));
        send_ray(aim(512, 512, 0, 0, 8192, 32'h20000, 32'h10000));
        send_ray(aim(512, 512, 0, 0, 8192, 32'h10000, 32'h10000));
        // field extremes
        send_ray(mk_ray(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575,
                        -2147483648, 2147483647));
        send_ray(mk_ray(1048575, 1048575, 1048575, -1048576, -1048576, -1048576,
                        -2147483648, 2147483647));
        send_ray(mk_ray(0, 0, 1048575, 0, 0, -1, -2147483648, 2147483647));
        // most negative normal, its negation saturates on the inside face
        set_quad(pack3(-16384, -16384, 4096), pack3(32768, 0, 0), pack3(0, 32768, 0),
                 pack3(0, 0, -1048576), 32'(-4096 * 64), 16'd0);
        send_ray(aim(512, 512, 0, 0, 8192, 0, 32'h7fff_ffff));
        send_ray(aim(512, 512, 0, 0, -8192, 0, 32'h7fff_ffff));
        // quad running past the coordinate range, hit point saturates
        set_quad(pack3(1040000, 0, 0), pack3(1000000, 0, 0), pack3(0, 65536, 0),
                 pack3(0, 0, 524288), 32'd0, 16'd65535);
        send_ray(mk_ray(1040000, 32768, 8192, 500000, 0, -8192, 0, 32'h7fff_ffff));
        send_ray(mk_ray(-1040000, 32768, 8192, -1000000, 0, -8192, 0, 32'h7fff_ffff));
        // degenerate quad, zero first edge
        set_quad(pack3(0, 0, 0), pack3(0, 0, 0), pack3(0, 65536, 0),
                 pack3(0, 0, 524288), 32'd0, 16'd1);
        send_ray(mk_ray(0, 1000, 8192, 0, 0, -8192, 0, 32'h7fff_ffff));
        // unused register indexes change nothing
        wait_drained();
        write_reg(IDX_UNUSED_LO, {$urandom, $urandom});
        write_reg(IDX_UNUSED_HI, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge aclk);
        send_ray(mk_ray(0, 1000, 8192, 0, 0, -8192, 0, 32'h7fff_ffff));
    endtask

    task automatic test_random_quads();
        repeat (8) begin
            random_quad();
            repeat (220) send_ray($urandom_range(0, 4) == 0 ? noise_ray() : random_aimed());
        end
    endtask

    task automatic test_random_registers();
        repeat (2) begin
            set_quad({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, $urandom, 16'($urandom));
            repeat (100) send_ray(noise_ray());
        end
    endtask

    // back to back, no idling on either side
    task automatic test_full_rate();
        random_quad();
        quiet = 1'b1;
        repeat (200) send_ray(random_aimed());
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest expected record
    always @(posedge aclk) begin
        hit_rec_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.hit = m_hit;
            got.t_hit = m_t_hit;
            got.pt = {m_point_z, m_point_y, m_point_x};
            got.fn = {m_face_normal_z, m_face_normal_y, m_face_normal_x};
            got.inner = m_inside_face;
            n_records++;
            if (hit_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("result beat with nothing expected: %p", got);
            end else begin
                want = hit_q.pop_front();
                if (got.hit) n_hits++;
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) $display("record %0d mismatch\n  exp %p\n  got %p",
                                              n_records, want, got);
                end
            end
        end
    end

    // watchdog on beats of any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed();
        test_random_quads();
        test_random_registers();
        test_full_rate();
        wait_drained();
        $display("%0d rays over %0d register writes, %0d records with %0d hits",
                 n_rays, n_writes, n_records, n_hits);
        n_bad += hit_q.size();
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/rqi_pkg.sv
rtl/rqi_wide_mul.sv
rtl/rqi_divider.sv
rtl/rqi_cfg.sv
rtl/ray_quad_intersect.sv
rtl/rqi_checker.sv
dv/tb_top.sv
